[rtl/core/sbh_pkg.sv]
// Shared types, constants and SHA-256 round functions for the byte stream hasher.
// No dependencies; used by the top level and the checker.
package sbh_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0]  byte_t;
	typedef logic [2:0]  word_idx_t;

	// Storage geometry
	localparam int WORD_W      = 32;
	localparam int BUF_DEPTH   = 16;
	localparam int CHAIN_DEPTH = 8;
	localparam int ROUNDS      = 64;

	// Buffer word slots of the 64-bit length field
	localparam int LEN_HI_IDX = BUF_DEPTH - 2;
	localparam int LEN_LO_IDX = BUF_DEPTH - 1;

	// Padding marker byte and bit count per byte
	localparam byte_t PAD_MARK   = 8'h80;
	localparam int    BYTE_BITS  = 8;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic word_t bsig0(input word_t x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t ssig0(input word_t x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t ssig1(input word_t x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t ch_fn(input word_t x, input word_t y, input word_t z);
		ch_fn = (x & y) ^ (~x & z);
	endfunction

	function automatic word_t maj_fn(input word_t x, input word_t y, input word_t z);
		maj_fn = (x & y) ^ (x & z) ^ (y & z);
	endfunction

	// Initial chaining values
	function automatic word_t init_hash(input word_idx_t idx);
		case (idx)
			3'd0: init_hash = 32'h6a09e667;
			3'd1: init_hash = 32'hbb67ae85;
			3'd2: init_hash = 32'h3c6ef372;
			3'd3: init_hash = 32'ha54ff53a;
			3'd4: init_hash = 32'h510e527f;
			3'd5: init_hash = 32'h9b05688c;
			3'd6: init_hash = 32'h1f83d9ab;
			default: init_hash = 32'h5be0cd19;
		endcase
	endfunction

	// Round constants
	function automatic word_t round_k(input logic [5:0] idx);
		case (idx)
			6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
			6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
			6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
			6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;
			default: round_k = 32'hc67178f2;
		endcase
	endfunction

endpackage

[rtl/core/sbh_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependencies.
module sbh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/sha256_byte_stream_hasher_top.sv]
// SHA-256 byte stream hasher: byte packing, padding, compression and digest output.
// Depends on sbh_pkg and two sbh_ram instances (block buffer, chaining values).
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid/in_ready, data_byte, byte_present,    | into block
//          | end_of_message                                 |
//  out     | out_valid/out_ready, digest_word, word_number, | out of block
//          | final_word                                     |
//
// Bytes are taken one per cycle while the current 64-byte block fills.
// Each block compression holds off input while it streams the buffer RAM and
// chaining RAM into the round registers, runs 64 rounds, then adds back into
// the chaining RAM (one read and one write per word). Ending a message costs
// padding writes plus one or two compressions; the digest leaves one word per
// update read and write, slowed by out_ready.
// Reset is asynchronous; the chaining RAM reads as the initial hash until written.
module sha256_byte_stream_hasher_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sbh_pkg::byte_t     data_byte,
	input  logic               byte_present,
	input  logic               end_of_message,
	output logic               out_valid,
	input  logic               out_ready,
	output sbh_pkg::word_t     digest_word,
	output sbh_pkg::word_idx_t word_number,
	output logic               final_word
);

	import sbh_pkg::*;

	localparam int BUF_AW = $clog2(BUF_DEPTH);
	localparam int CH_AW  = $clog2(CHAIN_DEPTH);
	localparam int RND_AW = $clog2(ROUNDS);

	localparam logic [BUF_AW:0] ZERO_END   = (BUF_AW+1)'(LEN_HI_IDX);
	localparam logic [BUF_AW:0] ZERO_END_X = (BUF_AW+1)'(BUF_DEPTH);

	// Sequencer states
	localparam logic [3:0] ST_ACC = 4'd0;  // taking bytes
	localparam logic [3:0] ST_PAD = 4'd1;  // write the word holding the marker
	localparam logic [3:0] ST_PZ  = 4'd2;  // zero fill
	localparam logic [3:0] ST_PLH = 4'd3;  // length high word
	localparam logic [3:0] ST_PLL = 4'd4;  // length low word
	localparam logic [3:0] ST_CL  = 4'd5;  // load schedule and working vars
	localparam logic [3:0] ST_CR  = 4'd6;  // rounds
	localparam logic [3:0] ST_UR  = 4'd7;  // chain update read
	localparam logic [3:0] ST_UW  = 4'd8;  // chain update write / digest out

	logic [3:0]              state_q;
	logic [5:0]              fill_q;
	logic [63:0]             len_q;
	logic                    end_q;
	logic                    extra_q;
	logic                    final_q;
	logic [BUF_AW:0]         pad_idx_q;
	logic [BUF_AW:0]         ld_cnt_q;
	logic [RND_AW-1:0]       rnd_q;
	logic [CH_AW-1:0]        upd_idx_q;
	logic [CHAIN_DEPTH-1:0]  vld_q;
	logic                    out_valid_q;

	word_t                   word_q;
	word_t                   w_q    [BUF_DEPTH];
	word_t                   work_q [CHAIN_DEPTH];
	logic                    cap_vld_s1;
	logic [BUF_AW-1:0]       cap_idx_s1;
	logic [CH_AW-1:0]        chain_addr_s1;
	logic                    chain_hit_s1;
	word_t                   out_word_q;
	logic [CH_AW-1:0]        out_num_q;
	logic                    out_last_q;

	logic                    in_fire;
	logic                    buf_we;
	logic [BUF_AW-1:0]       buf_waddr;
	word_t                   buf_wdata;
	word_t                   buf_rdata;
	logic                    chain_we;
	logic [CH_AW-1:0]        chain_raddr;
	word_t                   chain_rdata;
	word_t                   chain_rd;
	word_t                   chain_sum;
	word_t                   pad_word;
	word_t                   t1;
	word_t                   t2;
	word_t                   w_new;
	logic [BUF_AW:0]         zero_end;
	logic                    out_load;
	logic                    upd_adv;

	assign in_ready = (state_q == ST_ACC);
	assign in_fire  = in_valid && in_ready;

	// Word holding the 0x80 marker after the bytes already packed
	always_comb begin
		case (fill_q[1:0])
			2'd0:    pad_word = {PAD_MARK, 24'h0};
			2'd1:    pad_word = {word_q[7:0], PAD_MARK, 16'h0};
			2'd2:    pad_word = {word_q[15:0], PAD_MARK, 8'h0};
			default: pad_word = {word_q[23:0], PAD_MARK};
		endcase
	end

	assign zero_end = extra_q ? ZERO_END_X : ZERO_END;

	// Block buffer write port
	always_comb begin
		buf_we    = 1'b0;
		buf_waddr = fill_q[5:2];
		buf_wdata = pad_word;
		case (state_q)
			ST_ACC: begin
				buf_we    = in_fire && byte_present && (fill_q[1:0] == 2'd3);
				buf_wdata = {word_q[23:0], data_byte};
			end
			ST_PAD: begin
				buf_we = 1'b1;
			end
			ST_PZ: begin
				buf_we    = (pad_idx_q < zero_end);
				buf_waddr = pad_idx_q[BUF_AW-1:0];
				buf_wdata = '0;
			end
			ST_PLH: begin
				buf_we    = 1'b1;
				buf_waddr = BUF_AW'(LEN_HI_IDX);
				buf_wdata = len_q[63:32];
			end
			ST_PLL: begin
				buf_we    = 1'b1;
				buf_waddr = BUF_AW'(LEN_LO_IDX);
				buf_wdata = len_q[31:0];
			end
			default: begin
				buf_we = 1'b0;
			end
		endcase
	end

	sbh_ram #(
		.WIDTH (WORD_W),
		.DEPTH (BUF_DEPTH)
	) u_buf_ram (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (buf_wdata),
		.raddr (ld_cnt_q[BUF_AW-1:0]),
		.rdata (buf_rdata)
	);

	// Chaining value RAM; unwritten entries read as the initial hash
	assign chain_raddr = (state_q == ST_CL) ? ld_cnt_q[CH_AW-1:0] : upd_idx_q;
	assign chain_rd    = chain_hit_s1 ? chain_rdata : init_hash(chain_addr_s1);
	assign chain_sum   = chain_rd + work_q[upd_idx_q];
	assign out_load    = (state_q == ST_UW) && final_q && (!out_valid_q || out_ready);
	assign upd_adv     = !final_q || out_load;
	assign chain_we    = (state_q == ST_UW) && !final_q;

	sbh_ram #(
		.WIDTH (WORD_W),
		.DEPTH (CHAIN_DEPTH)
	) u_chain_ram (
		.clk   (clk),
		.we    (chain_we),
		.waddr (upd_idx_q),
		.wdata (chain_sum),
		.raddr (chain_raddr),
		.rdata (chain_rdata)
	);

	// Round datapath
	always_comb begin
		t1 = work_q[7] + bsig1(work_q[4]) + ch_fn(work_q[4], work_q[5], work_q[6])
		     + round_k(rnd_q) + w_q[0];
		t2 = bsig0(work_q[0]) + maj_fn(work_q[0], work_q[1], work_q[2]);
		w_new = w_q[0] + ssig0(w_q[1]) + w_q[9] + ssig1(w_q[14]);
	end

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			fill_q      <= '0;
			len_q       <= '0;
			end_q       <= 1'b0;
			extra_q     <= 1'b0;
			final_q     <= 1'b0;
			pad_idx_q   <= '0;
			ld_cnt_q    <= '0;
			rnd_q       <= '0;
			upd_idx_q   <= '0;
			vld_q       <= '0;
			cap_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cap_vld_s1 <= (state_q == ST_CL) && !ld_cnt_q[BUF_AW];
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (chain_we) begin
				vld_q[upd_idx_q] <= 1'b1;
			end
			case (state_q)
				ST_ACC: begin
					if (in_fire) begin
						if (byte_present) begin
							fill_q <= fill_q + 6'd1;
							len_q  <= len_q + 64'(BYTE_BITS);
						end
						if (byte_present && (fill_q == 6'd63)) begin
							end_q   <= end_of_message;
							final_q <= 1'b0;
							state_q <= ST_CL;
						end else if (end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					end_q     <= 1'b0;
					extra_q   <= (fill_q[5:3] == 3'b111);
					pad_idx_q <= {1'b0, fill_q[5:2]} + 1'b1;
					state_q   <= ST_PZ;
				end
				ST_PZ: begin
					if (pad_idx_q < zero_end) begin
						pad_idx_q <= pad_idx_q + 1'b1;
					end else if (extra_q) begin
						final_q <= 1'b0;
						state_q <= ST_CL;
					end else begin
						state_q <= ST_PLH;
					end
				end
				ST_PLH: begin
					state_q <= ST_PLL;
				end
				ST_PLL: begin
					final_q <= 1'b1;
					state_q <= ST_CL;
				end
				ST_CL: begin
					if (ld_cnt_q[BUF_AW]) begin
						ld_cnt_q <= '0;
						rnd_q    <= '0;
						state_q  <= ST_CR;
					end else begin
						ld_cnt_q <= ld_cnt_q + 1'b1;
					end
				end
				ST_CR: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == RND_AW'(ROUNDS - 1)) begin
						upd_idx_q <= '0;
						state_q   <= ST_UR;
					end
				end
				ST_UR: begin
					state_q <= ST_UW;
				end
				ST_UW: begin
					if (upd_adv) begin
						upd_idx_q <= upd_idx_q + 1'b1;
						if (upd_idx_q == CH_AW'(CHAIN_DEPTH - 1)) begin
							if (final_q) begin
								// digest out: back to a fresh message
								vld_q   <= '0;
								fill_q  <= '0;
								len_q   <= '0;
								final_q <= 1'b0;
								state_q <= ST_ACC;
							end else if (extra_q) begin
								// length spills into a fresh block
								extra_q   <= 1'b0;
								pad_idx_q <= '0;
								state_q   <= ST_PZ;
							end else if (end_q) begin
								state_q <= ST_PAD;
							end else begin
								state_q <= ST_ACC;
							end
						end else begin
							state_q <= ST_UR;
						end
					end
				end
				default: begin
					state_q <= ST_ACC;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_fire && byte_present) begin
			word_q <= {word_q[23:0], data_byte};
		end
		cap_idx_s1    <= ld_cnt_q[BUF_AW-1:0];
		chain_addr_s1 <= chain_raddr;
		chain_hit_s1  <= vld_q[chain_raddr];

		// schedule window: loaded from the buffer, then extended each round
		if (cap_vld_s1 || (state_q == ST_CR)) begin
			for (int i = 0; i < BUF_DEPTH - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[BUF_DEPTH-1] <= cap_vld_s1 ? buf_rdata : w_new;
		end

		// working variables a..h
		if (cap_vld_s1) begin
			if (cap_idx_s1 < BUF_AW'(CHAIN_DEPTH)) begin
				work_q[cap_idx_s1[CH_AW-1:0]] <= chain_rd;
			end
		end else if (state_q == ST_CR) begin
			work_q[0] <= t1 + t2;
			work_q[1] <= work_q[0];
			work_q[2] <= work_q[1];
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3] + t1;
			work_q[5] <= work_q[4];
			work_q[6] <= work_q[5];
			work_q[7] <= work_q[6];
		end

		if (out_load) begin
			out_word_q <= chain_sum;
			out_num_q  <= upd_idx_q;
			out_last_q <= (upd_idx_q == CH_AW'(CHAIN_DEPTH - 1));
		end
	end

	assign out_valid   = out_valid_q;
	assign digest_word = out_word_q;
	assign word_number = out_num_q;
	assign final_word  = out_last_q;

endmodule

[rtl/core/sbh_checker.sv]
// Port-level checks for the byte stream hasher, attached by bind.
// Depends on sbh_pkg for the digest field types.
module sbh_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input sbh_pkg::word_t     digest_word,
	input sbh_pkg::word_idx_t word_number,
	input logic               final_word
);

	import sbh_pkg::*;

	word_idx_t exp_num_q;

	// Expected index of the next digest item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_num_q <= '0;
		end else if (out_valid && out_ready) begin
			exp_num_q <= exp_num_q + 1'b1;
		end
	end

	// A stalled digest item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word)
			&& $stable(word_number) && $stable(final_word))
		else $error("digest item changed while stalled");

	// Words leave in order 0..7, message after message
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> word_number == exp_num_q)
		else $error("digest word out of order");

	// Last flag marks word seven only
	a_final_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> final_word == (word_number == 3'd7))
		else $error("final_word does not match word_number");

	// Nothing pending right after reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("out_valid high out of reset");

endmodule

bind sha256_byte_stream_hasher_top sbh_checker u_sbh_checker (.*);
